// ===== rtl/core/edf_and_weighted_round_robin_scheduler_core_assert.svh =====
// Assertion macros for the scheduler core.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef EDF_AND_WEIGHTED_ROUND_ROBIN_SCHEDULER_CORE_ASSERT_SVH
`define EDF_AND_WEIGHTED_ROUND_ROBIN_SCHEDULER_CORE_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define EDFWRR_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("scheduler assertion failed");

// A condition that must hold whenever a trigger is seen.
`define EDFWRR_ASSERT_IMPLIES(lbl, trig, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cond)) \
    else $error("scheduler assertion failed");

`endif

// ===== rtl/core/edfwrr_pkg.sv =====
// Shared types and constants of the EDF and round robin scheduler core.
// No dependencies.
`timescale 1ns / 1ps

package edfwrr_pkg;

  localparam int unsigned MaxTasksDef = 16;
  localparam logic [15:0] InitPrioReset = 16'd257;
  localparam logic [7:0] CreditMask = 8'hff;
  localparam int unsigned CreditShift = 8;

  // Command codes.
  localparam logic [2:0] OpAdd = 3'd0;
  localparam logic [2:0] OpTick = 3'd1;
  localparam logic [2:0] OpYield = 3'd2;
  localparam logic [2:0] OpDelay = 3'd3;
  localparam logic [2:0] OpSuspend = 3'd4;
  localparam logic [2:0] OpResume = 3'd5;

  // Task modes.
  localparam logic [2:0] ModeStopped = 3'd0;
  localparam logic [2:0] ModeReady = 3'd1;
  localparam logic [2:0] ModeRunning = 3'd2;
  localparam logic [2:0] ModeBlocked = 3'd3;
  localparam logic [2:0] ModeSuspended = 3'd4;

  // Result status codes.
  localparam logic [1:0] StatOk = 2'd0;
  localparam logic [1:0] StatReject = 2'd1;
  localparam logic [1:0] StatNoReady = 2'd2;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  target_task;
    logic [15:0] delay_ticks;
    logic [15:0] task_period;
    logic [15:0] task_deadline;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  running_task;
    logic        chosen_by_deadline;
    logic [31:0] switch_count;
  } res_t;

  // One task table row as held in the task memory.
  typedef struct packed {
    logic [15:0] delay_left;
    logic [15:0] period_length;
    logic [15:0] period_left;
    logic [15:0] deadline_length;
    logic [15:0] deadline_left;
    logic [15:0] priority_word;
  } task_rec_t;

  // Controls handed to the row update unit.
  typedef struct packed {
    logic tick;
    logic is_rt;
    logic is_cur;
    logic load_delay;
  } upd_ctl_t;

endpackage

// ===== rtl/core/edf_and_weighted_round_robin_scheduler_core.sv =====
// Top level of the EDF and weighted round robin scheduler core.
// Depends on edfwrr_pkg, edfwrr_ram, edfwrr_upd and the assertion header.
//
//   Port group     Direction  Handshake               Payload
//   in_*           input      in_valid_i/in_stall_o   edfwrr_pkg::cmd_t
//   out_*          output     out_valid_o/out_stall_i edfwrr_pkg::res_t
//   cfg_*          input      cfg_we_i                initial priority word
//
// Add, rejected commands and suspend or resume of another task go straight to the
// result. Tick, yield, delay and suspend or resume of the current task sweep the
// table through the row update unit, reading then writing each row; a tick then
// picks the earliest deadline. The round robin walks the table, reading each ready
// best-effort row and writing its credit back on the single memory port. Reset
// clears control state; rows are written by add first. Commands stall while busy.
`timescale 1ns / 1ps

module edf_and_weighted_round_robin_scheduler_core #(
  parameter int unsigned MAX_TASKS = edfwrr_pkg::MaxTasksDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  edfwrr_pkg::cmd_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output edfwrr_pkg::res_t  out_data_o,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i
);
  import edfwrr_pkg::*;

  localparam int unsigned IW = $clog2(MAX_TASKS);
  localparam int unsigned TW = $clog2(MAX_TASKS + 1);
  localparam int unsigned CW = 8;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSwRd = 3'd1;
  localparam logic [2:0] StSwWr = 3'd2;
  localparam logic [2:0] StPick = 3'd3;
  localparam logic [2:0] StRrStart = 3'd4;
  localparam logic [2:0] StRrStep = 3'd5;
  localparam logic [2:0] StRrWr = 3'd6;
  localparam logic [2:0] StEmit = 3'd7;

  logic [2:0]    state_q, state_d;
  logic [2:0]    mode_q [MAX_TASKS];
  logic [2:0]    mode_d [MAX_TASKS];
  logic [MAX_TASKS-1:0] rt_q, rt_d;
  logic [IW-1:0] cur_q, cur_d;
  logic [TW-1:0] total_q, total_d;
  logic [31:0]   cnt_q, cnt_d;
  logic [15:0]   prio_q;
  cmd_t          cmd_q, cmd_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] best_q, best_d;
  logic [15:0]   best_dl_q, best_dl_d;
  logic          found_q, found_d;
  logic [1:0]    st_q, st_d;
  logic          byd_q, byd_d;
  logic          out_vld_q, out_vld_d;
  res_t          out_q, out_d;

  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  task_rec_t     ram_wdata, ram_rdata, upd_rec, add_rec;
  upd_ctl_t      upd_ctl;
  logic [2:0]    upd_mode;
  logic          upd_cand;

  logic [CW-1:0] tgt_w, total_w;
  logic [IW-1:0] tgt_idx, n_idx, nxt_idx;
  logic          tgt_ok, cur_ok, any_rr, last_row;
  logic [7:0]    credit;

  edfwrr_ram #(
    .Width ($bits(task_rec_t)),
    .Depth (MAX_TASKS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Shared row update unit for the table sweep.
  assign upd_ctl.tick       = (cmd_q.op == OpTick);
  assign upd_ctl.is_rt      = rt_q[idx_q];
  assign upd_ctl.is_cur     = (idx_q == cur_q);
  assign upd_ctl.load_delay = (cmd_q.op == OpDelay) && (idx_q == cur_q);

  edfwrr_upd u_upd (
    .rec_i       (ram_rdata),
    .mode_i      (mode_q[idx_q]),
    .ctl_i       (upd_ctl),
    .new_delay_i (cmd_q.delay_ticks),
    .rec_o       (upd_rec),
    .mode_o      (upd_mode),
    .cand_o      (upd_cand)
  );

  // Index checks and helpers.
  assign tgt_w    = CW'(in_data_i.target_task);
  assign total_w  = CW'(total_q);
  assign tgt_idx  = IW'(tgt_w);
  assign n_idx    = total_q[IW-1:0];
  assign tgt_ok   = tgt_w < total_w;
  assign cur_ok   = (CW'(cur_q) < total_w) &&
                    (mode_q[cur_q] == ModeReady || mode_q[cur_q] == ModeRunning);
  assign last_row = (TW'(idx_q) + TW'(1)) == total_q;
  assign nxt_idx  = ((TW'(idx_q) + TW'(1)) == total_q) ? '0 : idx_q + IW'(1);
  assign credit   = ram_rdata.priority_word[7:0] - 8'd1;

  // Row written by an add command.
  always_comb begin
    add_rec.delay_left      = 16'd0;
    add_rec.period_length   = in_data_i.task_period;
    add_rec.period_left     = in_data_i.task_period;
    add_rec.deadline_length = in_data_i.task_deadline;
    add_rec.deadline_left   = in_data_i.task_deadline;
    add_rec.priority_word   = prio_q;
  end

  // Any ready best-effort task in the table.
  always_comb begin
    any_rr = 1'b0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      if (CW'(i) < total_w && mode_q[i] == ModeReady && !rt_q[i]) begin
        any_rr = 1'b1;
      end
    end
  end

  // Command sequencer.
  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    rt_d      = rt_q;
    cur_d     = cur_q;
    total_d   = total_q;
    cnt_d     = cnt_q;
    cmd_d     = cmd_q;
    idx_d     = idx_q;
    best_d    = best_q;
    best_dl_d = best_dl_q;
    found_d   = found_q;
    st_d      = st_q;
    byd_d     = byd_q;
    out_vld_d = out_vld_q && out_stall_i;
    out_d     = out_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = upd_rec;
    ram_raddr = idx_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_d   = in_data_i;
          byd_d   = 1'b0;
          st_d    = StatReject;
          idx_d   = '0;
          found_d = 1'b0;
          state_d = StEmit;
          case (in_data_i.op)
            OpAdd: begin
              if (total_q < TW'(MAX_TASKS)) begin
                ram_we        = 1'b1;
                ram_waddr     = n_idx;
                ram_wdata     = add_rec;
                mode_d[n_idx] = ModeReady;
                rt_d[n_idx]   = in_data_i.task_deadline != 16'd0;
                cur_d         = n_idx;
                total_d       = total_q + TW'(1);
                st_d          = StatOk;
              end
            end
            OpTick, OpYield: begin
              if (total_q == '0) begin
                st_d = StatNoReady;
              end else begin
                state_d = StSwRd;
              end
            end
            OpDelay: begin
              if (cur_ok) begin
                mode_d[cur_q] = ModeBlocked;
                state_d       = StSwRd;
              end
            end
            OpSuspend: begin
              if (tgt_ok && (mode_q[tgt_idx] == ModeReady ||
                             mode_q[tgt_idx] == ModeRunning)) begin
                mode_d[tgt_idx] = ModeSuspended;
                st_d            = StatOk;
                if (tgt_idx == cur_q) begin
                  state_d = StSwRd;
                end
              end
            end
            OpResume: begin
              if (tgt_ok && mode_q[tgt_idx] == ModeSuspended) begin
                mode_d[tgt_idx] = ModeReady;
                st_d            = StatOk;
                if (tgt_idx == cur_q) begin
                  state_d = StSwRd;
                end
              end
            end
            default: st_d = StatReject;
          endcase
        end
      end
      StSwRd: begin
        state_d = StSwWr;
      end
      StSwWr: begin
        // Write back the updated row and track the earliest deadline.
        ram_we        = 1'b1;
        mode_d[idx_q] = upd_mode;
        if (upd_ctl.tick && upd_cand &&
            (!found_q || upd_rec.deadline_left < best_dl_q)) begin
          found_d   = 1'b1;
          best_d    = idx_q;
          best_dl_d = upd_rec.deadline_left;
        end
        if (last_row) begin
          state_d = upd_ctl.tick ? StPick : StRrStart;
        end else begin
          idx_d   = idx_q + IW'(1);
          state_d = StSwRd;
        end
      end
      StPick: begin
        if (found_q) begin
          mode_d[best_q] = ModeRunning;
          cur_d          = best_q;
          cnt_d          = cnt_q + 32'd1;
          st_d           = StatOk;
          byd_d          = 1'b1;
          state_d        = StEmit;
        end else begin
          state_d = StRrStart;
        end
      end
      StRrStart: begin
        if (any_rr) begin
          idx_d   = cur_q;
          state_d = StRrStep;
        end else begin
          st_d    = StatNoReady;
          state_d = StEmit;
        end
      end
      StRrStep: begin
        // Walk to the next task; read the row of a best-effort candidate.
        idx_d     = nxt_idx;
        ram_raddr = nxt_idx;
        if (mode_q[nxt_idx] == ModeReady && !rt_q[nxt_idx]) begin
          state_d = StRrWr;
        end
      end
      StRrWr: begin
        // Spend one credit; the task whose credit runs out is run.
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        if (credit == 8'd0) begin
          ram_wdata.priority_word[7:0] =
            8'((ram_rdata.priority_word >> CreditShift) & 16'(CreditMask));
          mode_d[idx_q] = ModeRunning;
          cur_d         = idx_q;
          cnt_d         = cnt_q + 32'd1;
          st_d          = StatOk;
          state_d       = StEmit;
        end else begin
          ram_wdata.priority_word[7:0] = credit;
          state_d = StRrStep;
        end
      end
      StEmit: begin
        if (!out_vld_q || !out_stall_i) begin
          out_vld_d                = 1'b1;
          out_d.status             = st_q;
          out_d.running_task       = 4'(cur_q);
          out_d.chosen_by_deadline = byd_q;
          out_d.switch_count       = cnt_q;
          state_d                  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      for (int i = 0; i < MAX_TASKS; i++) begin
        mode_q[i] <= ModeStopped;
      end
      rt_q      <= '0;
      cur_q     <= '0;
      total_q   <= '0;
      cnt_q     <= '0;
      prio_q    <= InitPrioReset;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      mode_q    <= mode_d;
      rt_q      <= rt_d;
      cur_q     <= cur_d;
      total_q   <= total_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        prio_q <= cfg_wdata_i;
      end
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    idx_q     <= idx_d;
    best_q    <= best_d;
    best_dl_q <= best_dl_d;
    found_q   <= found_d;
    st_q      <= st_d;
    byd_q     <= byd_d;
    out_q     <= out_d;
  end

  assign in_stall_o  = state_q != StIdle;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  `include "edf_and_weighted_round_robin_scheduler_core_assert.svh"

  `EDFWRR_ASSERT_ALWAYS(a_total_max, total_q <= TW'(MAX_TASKS))
  `EDFWRR_ASSERT_IMPLIES(a_cur_in_table, total_q != '0, CW'(cur_q) < total_w)
  `EDFWRR_ASSERT_IMPLIES(a_count_on_decision, cnt_q != $past(cnt_q),
    $past(state_q) == StPick || $past(state_q) == StRrWr)
  `EDFWRR_ASSERT_IMPLIES(a_result_from_emit, out_vld_q && !$past(out_vld_q),
    $past(state_q) == StEmit)

endmodule

// ===== rtl/core/edfwrr_ram.sv =====
// Generic single write port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module edfwrr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/edfwrr_upd.sv =====
// Row update unit: delay countdown, real-time counters and demotion of one task.
// Depends on edfwrr_pkg.
`timescale 1ns / 1ps

module edfwrr_upd (
  input  edfwrr_pkg::task_rec_t rec_i,
  input  logic [2:0]            mode_i,
  input  edfwrr_pkg::upd_ctl_t  ctl_i,
  input  logic [15:0]           new_delay_i,
  output edfwrr_pkg::task_rec_t rec_o,
  output logic [2:0]            mode_o,
  output logic                  cand_o
);
  import edfwrr_pkg::*;

  always_comb begin
    rec_o  = rec_i;
    mode_o = mode_i;
    if (ctl_i.load_delay) begin
      rec_o.delay_left = new_delay_i;
    end
    // A blocked task counts down and becomes ready at zero.
    if (mode_o == ModeBlocked && rec_o.delay_left != 16'd0) begin
      rec_o.delay_left = rec_o.delay_left - 16'd1;
      if (rec_o.delay_left == 16'd0) begin
        mode_o = ModeReady;
      end
    end
    // Real-time counters of ready or running tasks advance on a tick.
    if (ctl_i.tick && ctl_i.is_rt && (mode_o == ModeReady || mode_o == ModeRunning)) begin
      if (rec_o.deadline_left != 16'd0) begin
        rec_o.deadline_left = rec_o.deadline_left - 16'd1;
      end
      if (rec_o.period_left <= 16'd1) begin
        rec_o.period_left   = rec_o.period_length;
        rec_o.deadline_left = rec_o.deadline_length;
      end else begin
        rec_o.period_left = rec_o.period_left - 16'd1;
      end
    end
    // The current task gives up the processor.
    if (ctl_i.is_cur && mode_o == ModeRunning) begin
      mode_o = ModeReady;
    end
    cand_o = ctl_i.is_rt && mode_o == ModeReady;
  end

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the EDF and weighted round robin scheduler core.
// Depends on edfwrr_pkg and edf_and_weighted_round_robin_scheduler_core.
`timescale 1ns / 1ps

module testbench;
  import edfwrr_pkg::*;

  // Command codes that the block does not implement.
  localparam logic [2:0] OpSpare6 = 3'd6;
  localparam logic [2:0] OpSpare7 = 3'd7;

  // Task table mirror that predicts the result of every command.
  class sched_book;
    logic [2:0]  mode[MaxTasksDef];
    logic [15:0] blk_left[MaxTasksDef];
    logic [15:0] per_len[MaxTasksDef];
    logic [15:0] per_left[MaxTasksDef];
    logic [15:0] dl_len[MaxTasksDef];
    logic [15:0] dl_left[MaxTasksDef];
    logic [15:0] prio[MaxTasksDef];
    int unsigned cur;
    int unsigned total;
    logic [31:0] decisions;
    logic [15:0] init_prio;
    res_t        expected_q[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned edf_picks;
    int unsigned rejects;
    int unsigned idle_answers;

    function new();
      init_prio = InitPrioReset;
      cur = 0;
      total = 0;
      decisions = '0;
      errors = 0;
      checked = 0;
      edf_picks = 0;
      rejects = 0;
      idle_answers = 0;
      foreach (mode[i]) mode[i] = ModeStopped;
    endfunction

    function void answer(logic [1:0] st, logic by_dl);
      res_t r;
      r.status = st;
      r.running_task = cur[3:0];
      r.chosen_by_deadline = by_dl;
      r.switch_count = decisions;
      expected_q.push_back(r);
    endfunction

    // Blocked tasks count their delay down and wake at zero.
    function void age_delays();
      for (int i = 0; i < total; i++) begin
        if (mode[i] == ModeBlocked && blk_left[i] != 0) begin
          blk_left[i]--;
          if (blk_left[i] == 0) mode[i] = ModeReady;
        end
      end
    endfunction

    // Real-time counters of ready and running tasks.
    function void age_deadlines();
      for (int i = 0; i < total; i++) begin
        if (dl_len[i] != 0 && (mode[i] == ModeReady || mode[i] == ModeRunning)) begin
          if (dl_left[i] != 0) dl_left[i]--;
          if (per_left[i] <= 1) begin
            per_left[i] = per_len[i];
            dl_left[i] = dl_len[i];
          end else begin
            per_left[i]--;
          end
        end
      end
    endfunction

    function void demote();
      if (cur < total && mode[cur] == ModeRunning) mode[cur] = ModeReady;
    endfunction

    function void dispatch(int unsigned idx);
      cur = idx;
      mode[idx] = ModeRunning;
      decisions++;
    endfunction

    function bit best_effort_ready(int unsigned i);
      return mode[i] == ModeReady && dl_len[i] == 0;
    endfunction

    // Credit walk over ready best-effort tasks.
    function void credit_walk();
      bit          any;
      int unsigned idx;
      logic [7:0]  credit;
      any = 0;
      for (int i = 0; i < total; i++) if (best_effort_ready(i)) any = 1;
      if (!any) begin
        answer(StatNoReady, 1'b0);
        return;
      end
      idx = cur;
      for (int s = 0; s < 257 * MaxTasksDef + 1; s++) begin
        idx = (idx + 1) % total;
        if (best_effort_ready(idx)) begin
          credit = prio[idx][7:0] - 8'd1;
          if (credit == 0) begin
            prio[idx] = {prio[idx][15:8], prio[idx][15:8]};
            dispatch(idx);
            answer(StatOk, 1'b0);
            return;
          end
          prio[idx][7:0] = credit;
        end
      end
      answer(StatNoReady, 1'b0);
    endfunction

    function void yield_now();
      if (total == 0) begin
        answer(StatNoReady, 1'b0);
        return;
      end
      age_delays();
      demote();
      credit_walk();
    endfunction

    function void tick_now();
      bit          found;
      int unsigned best;
      found = 0;
      best = 0;
      if (total == 0) begin
        answer(StatNoReady, 1'b0);
        return;
      end
      age_delays();
      age_deadlines();
      demote();
      for (int i = 0; i < total; i++) begin
        if (dl_len[i] != 0 && mode[i] == ModeReady) begin
          if (!found || dl_left[i] < dl_left[best]) begin
            best = i;
            found = 1;
          end
        end
      end
      if (found) begin
        dispatch(best);
        answer(StatOk, 1'b1);
      end else begin
        credit_walk();
      end
    endfunction

    // Works out the result of one accepted command.
    function void note_cmd(cmd_t c);
      int unsigned t;
      t = c.target_task;
      case (c.op)
        OpAdd: begin
          if (total >= MaxTasksDef) begin
            answer(StatReject, 1'b0);
          end else begin
            mode[total] = ModeReady;
            blk_left[total] = '0;
            per_len[total] = c.task_period;
            per_left[total] = c.task_period;
            dl_len[total] = c.task_deadline;
            dl_left[total] = c.task_deadline;
            prio[total] = init_prio;
            cur = total;
            total++;
            answer(StatOk, 1'b0);
          end
        end
        OpTick: tick_now();
        OpYield: yield_now();
        OpDelay: begin
          if (cur >= total || (mode[cur] != ModeReady && mode[cur] != ModeRunning)) begin
            answer(StatReject, 1'b0);
          end else begin
            blk_left[cur] = c.delay_ticks;
            mode[cur] = ModeBlocked;
            yield_now();
          end
        end
        OpSuspend: begin
          if (t >= total || (mode[t] != ModeReady && mode[t] != ModeRunning)) begin
            answer(StatReject, 1'b0);
          end else begin
            mode[t] = ModeSuspended;
            if (t == cur) yield_now();
            else answer(StatOk, 1'b0);
          end
        end
        OpResume: begin
          if (t >= total || mode[t] != ModeSuspended) begin
            answer(StatReject, 1'b0);
          end else begin
            mode[t] = ModeReady;
            if (t == cur) yield_now();
            else answer(StatOk, 1'b0);
          end
        end
        default: answer(StatReject, 1'b0);
      endcase
    endfunction

    // Compares one transferred result with the oldest prediction.
    function void check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: %p", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (want.chosen_by_deadline) edf_picks++;
      if (want.status == StatReject) rejects++;
      if (want.status == StatNoReady) idle_answers++;
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.running_task !== want.running_task) begin
        $error("running_task: expected %0d, got %0d", want.running_task, got.running_task);
        errors++;
      end
      if (got.chosen_by_deadline !== want.chosen_by_deadline) begin
        $error("chosen_by_deadline: expected %0d, got %0d",
               want.chosen_by_deadline, got.chosen_by_deadline);
        errors++;
      end
      if (got.switch_count !== want.switch_count) begin
        $error("switch_count: expected %0d, got %0d", want.switch_count, got.switch_count);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  cmd_t        in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  res_t        out_data_o;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;

  sched_book   book = new();
  bit          calm;
  int unsigned sent;

  edf_and_weighted_round_robin_scheduler_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Clock with a 10 ns period.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Offers one command after a random gap and waits for its transfer.
  task automatic send_cmd(cmd_t c);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= c;
    do @(posedge clk_i); while (in_stall_o);
    book.note_cmd(c);
    sent++;
  endtask

  task automatic send_op(logic [2:0] op, logic [3:0] tgt, logic [15:0] dly,
                         logic [15:0] per, logic [15:0] dl);
    cmd_t c;
    c.op = op;
    c.target_task = tgt;
    c.delay_ticks = dly;
    c.task_period = per;
    c.task_deadline = dl;
    send_cmd(c);
  endtask

  // Waits for every result, then writes the priority register.
  task automatic write_prio(logic [15:0] value);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (book.expected_q.size() != 0);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    book.init_prio = value;
  endtask

  // Random command, biased toward ticks and valid targets.
  function automatic cmd_t random_cmd();
    cmd_t        c;
    int unsigned pick;
    c = cmd_t'($bits(cmd_t)'({$urandom, $urandom}));
    pick = $urandom_range(0, 99);
    if (pick < 8) c.op = OpAdd;
    else if (pick < 43) c.op = OpTick;
    else if (pick < 58) c.op = OpYield;
    else if (pick < 70) c.op = OpDelay;
    else if (pick < 82) c.op = OpSuspend;
    else if (pick < 94) c.op = OpResume;
    else c.op = $urandom_range(0, 1) ? OpSpare6 : OpSpare7;
    if ($urandom_range(0, 9) != 0) c.target_task = 4'($urandom_range(0, book.total));
    pick = $urandom_range(0, 99);
    if (pick < 2) c.delay_ticks = '0;
    else if (pick < 93) c.delay_ticks = 16'($urandom_range(1, 6));
    if ($urandom_range(0, 19) != 0) begin
      c.task_period = 16'($urandom_range(0, 20));
      c.task_deadline = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, 20));
    end
    return c;
  endfunction

  // Result side: random stalls after each transfer, one long hold-off.
  initial begin : result_sink
    int unsigned hold;
    hold = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        book.check_result(out_data_o);
        hold = calm ? 0 : $urandom_range(0, 8);
        if (book.checked == 150) hold = 400;
      end
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        hold--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Stimulus: directed corner cases, then random phases per priority setting.
  initial begin : stimulus
    logic [15:0] prio_set[5];
    prio_set = '{16'h0101, 16'h0000, 16'hFFFF, 16'h0302, 16'h0001};
    sent = 0;
    calm = 0;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table, bad indexes and unused codes.
    send_op(OpTick, 4'd0, 16'd0, 16'd0, 16'd0);
    send_op(OpYield, 4'd0, 16'd0, 16'd0, 16'd0);
    send_op(OpDelay, 4'd0, 16'd3, 16'd0, 16'd0);
    send_op(OpSuspend, 4'd0, 16'd0, 16'd0, 16'd0);
    send_op(OpResume, 4'd15, 16'd0, 16'd0, 16'd0);
    send_op(OpSpare6, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_op(OpSpare7, 4'd0, 16'd0, 16'd0, 16'd0);
    // Best-effort tasks, then real-time ones with zero and maximum periods.
    send_op(OpAdd, 4'd0, 16'd0, 16'd0, 16'd0);
    send_op(OpYield, 4'd0, 16'd0, 16'd0, 16'd0);
    send_op(OpAdd, 4'd0, 16'd0, 16'd0, 16'd0);
    send_op(OpAdd, 4'd0, 16'd0, 16'd0, 16'd5);
    send_op(OpAdd, 4'd0, 16'd0, 16'hFFFF, 16'hFFFF);
    send_op(OpTick, 4'd0, 16'd0, 16'd0, 16'd0);
    send_op(OpTick, 4'd0, 16'd0, 16'd0, 16'd0);
    // Delay of one wakes at once; a long delay keeps the task blocked.
    send_op(OpDelay, 4'd0, 16'd1, 16'd0, 16'd0);
    send_op(OpDelay, 4'd0, 16'hFFFF, 16'd0, 16'd0);
    send_op(OpDelay, 4'd0, 16'd0, 16'd0, 16'd0);
    send_op(OpYield, 4'd0, 16'd0, 16'd0, 16'd0);
    // Suspend and resume of the current task, of another, and of a bad state.
    send_op(OpSuspend, 4'd2, 16'd0, 16'd0, 16'd0);
    send_op(OpSuspend, book.cur[3:0], 16'd0, 16'd0, 16'd0);
    send_op(OpResume, 4'd2, 16'd0, 16'd0, 16'd0);
    send_op(OpResume, 4'd0, 16'd0, 16'd0, 16'd0);
    send_op(OpSuspend, 4'd15, 16'd0, 16'd0, 16'd0);
    send_op(OpTick, 4'd0, 16'd0, 16'd0, 16'd0);

    // Random phases; the middle one runs without gaps on either side.
    foreach (prio_set[p]) begin
      write_prio(prio_set[p]);
      calm = (p == 2);
      repeat (80) send_cmd(random_cmd());
    end
    calm = 0;
    in_valid_i <= 1'b0;

    // Drain.
    do @(posedge clk_i); while (book.expected_q.size() != 0);
    repeat (50) @(posedge clk_i);
    $display("Ran %0d commands over %0d tasks: %0d deadline picks, %0d rejects, %0d idle.",
             sent, book.total, book.edf_picks, book.rejects, book.idle_answers);
    if (book.errors == 0 && book.expected_q.size() == 0) begin
      $display("PASS edf_and_weighted_round_robin_scheduler_core");
    end else begin
      $display("FAIL edf_and_weighted_round_robin_scheduler_core");
    end
    $finish;
  end

  // Watchdog.
  initial begin : watchdog
    #200ms;
    $display("FAIL edf_and_weighted_round_robin_scheduler_core");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/edfwrr_pkg.sv
rtl/core/edfwrr_ram.sv
rtl/core/edfwrr_upd.sv
rtl/core/edf_and_weighted_round_robin_scheduler_core.sv
verif/testbench.sv
